// File: rtl/core/modbus_register_slave_pdu_assert.svh
// assertion macros, clocked on clock and disabled during reset
`ifndef MODBUS_REGISTER_SLAVE_PDU_ASSERT_SVH
`define MODBUS_REGISTER_SLAVE_PDU_ASSERT_SVH
`ifndef SYNTHESIS
`define MRSP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define MRSP_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define MRSP_ASSERT(lbl, prop)
`define MRSP_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: rtl/core/mrsp_pkg.sv
`default_nettype none
package mrsp_pkg;
   localparam int NUM_REGS_DEF = 64;
   localparam int MASK_W = 64;
   localparam int MASK_IW = 6;
   localparam int FQ_DEPTH = 4;
   localparam int OQ_DEPTH = 4;

   localparam logic [7:0] FC_READ = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h10;
   localparam logic [15:0] MAX_READ_QTY = 16'h007D;
   localparam logic [15:0] MAX_WRITE_QTY = 16'h007B;
   localparam logic [7:0] EXC_OFFSET = 8'h80;

   localparam logic CMD_REQ = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [1:0] CSR_MASK = 2'd0;
   localparam logic [1:0] CSR_EXC_FN = 2'd1;
   localparam logic [1:0] CSR_EXC_ADDR = 2'd2;
   localparam logic [1:0] CSR_EXC_QTY = 2'd3;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_item_type;

   typedef struct packed {
      req_item_type item;
      logic [7:0]   pos;
   } fq_entry_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [7:0]        exc_fn;
      logic [7:0]        exc_addr;
      logic [7:0]        exc_qty;
   } cfg_type;

   typedef enum logic {
      BK_RUN,
      BK_FILL
   } back_state_type;

   function automatic logic qty_bad_read(logic [15:0] q);
      return (q == 16'd0) || (q > MAX_READ_QTY);
   endfunction

   function automatic logic qty_bad_write(logic [15:0] q, logic [7:0] dbc);
      return (q == 16'd0) || (q > MAX_WRITE_QTY) || ({9'd0, dbc} != {q, 1'b0});
   endfunction

   function automatic logic range_bad(logic [15:0] start, logic [15:0] q, logic [16:0] num);
      return ({1'b0, start} + {1'b0, q}) > num;
   endfunction
endpackage
`default_nettype wire

// File: rtl/core/modbus_register_slave_pdu.sv
// a pull item's result is registered in the s2 stage, then written into the output queue
// throughput: one item per cycle; pulls wait for output queue room, and after a write
// request's last byte, items wait as the single register store port zero-fills the rest
// reset: synchronous, clears control state, registers read as zero until written
// configuration resets to mask 0 and exception codes 1, 2, 3
`default_nettype none
module modbus_register_slave_pdu #(
   parameter int NUM_REGS = mrsp_pkg::NUM_REGS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   output logic                   full,
   input  mrsp_pkg::req_item_type req_item,
   output logic                   empty,
   input  wire                    pop,
   output mrsp_pkg::rsp_item_type rsp_item,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire [4:0]              paddr,
   input  wire [63:0]             pwdata,
   output logic [63:0]            prdata,
   output logic                   pready
);
   logic [63:0] mask_ff;
   logic [7:0]  exc_fn_ff, exc_addr_ff, exc_qty_ff;
   mrsp_pkg::cfg_type cfg;
   logic        head_valid, deq, oq_wr;
   mrsp_pkg::fq_entry_type head;
   mrsp_pkg::rsp_item_type oq_item;
   logic [$clog2(mrsp_pkg::OQ_DEPTH+1)-1:0] oq_level;

   assign pready = 1'b1;
   assign cfg = '{mask: mask_ff, exc_fn: exc_fn_ff, exc_addr: exc_addr_ff,
                  exc_qty: exc_qty_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 64'd0;
         exc_fn_ff <= 8'd1;
         exc_addr_ff <= 8'd2;
         exc_qty_ff <= 8'd3;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:3])
            mrsp_pkg::CSR_MASK: mask_ff <= pwdata;
            mrsp_pkg::CSR_EXC_FN: exc_fn_ff <= pwdata[7:0];
            mrsp_pkg::CSR_EXC_ADDR: exc_addr_ff <= pwdata[7:0];
            mrsp_pkg::CSR_EXC_QTY: exc_qty_ff <= pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:3])
         mrsp_pkg::CSR_MASK: prdata = mask_ff;
         mrsp_pkg::CSR_EXC_FN: prdata = {56'd0, exc_fn_ff};
         mrsp_pkg::CSR_EXC_ADDR: prdata = {56'd0, exc_addr_ff};
         mrsp_pkg::CSR_EXC_QTY: prdata = {56'd0, exc_qty_ff};
      endcase
   end

   mrsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .deq        (deq),
      .head_valid (head_valid),
      .head       (head)
   );

   mrsp_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .deq        (deq),
      .oq_level   (oq_level),
      .oq_wr      (oq_wr),
      .oq_item    (oq_item)
   );

   mrsp_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .wr       (oq_wr),
      .wr_item  (oq_item),
      .level    (oq_level),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );
endmodule
`default_nettype wire

// File: rtl/core/mrsp_front.sv
`default_nettype none
module mrsp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  mrsp_pkg::req_item_type req_item,
   input  wire                   deq,
   output logic                  head_valid,
   output mrsp_pkg::fq_entry_type head
);
   localparam int AW = $clog2(mrsp_pkg::FQ_DEPTH);
   localparam int CW = $clog2(mrsp_pkg::FQ_DEPTH + 1);

   mrsp_pkg::fq_entry_type fq_ff [mrsp_pkg::FQ_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    pos_ff, pos_in;
   logic          acc;
   logic          pop_ok;

   assign full = (count_ff == CW'(mrsp_pkg::FQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head = fq_ff[rd_ptr_ff];
   assign acc = push && !full;
   assign pop_ok = deq && head_valid;

   // byte position within the current request
   always_comb begin
      pos_in = pos_ff;
      if (acc && (req_item.cmd == mrsp_pkg::CMD_REQ)) begin
         if (req_item.in_last) begin
            pos_in = 8'd0;
         end else if (pos_ff != 8'hFF) begin
            pos_in = pos_ff + 8'd1;
         end
      end
      wr_ptr_in = acc ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in = count_ff + CW'(acc) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         fq_ff[wr_ptr_ff] <= '{item: req_item, pos: pos_ff};
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/mrsp_outq.sv
`default_nettype none
module mrsp_outq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    wr,
   input  mrsp_pkg::rsp_item_type wr_item,
   output logic [$clog2(mrsp_pkg::OQ_DEPTH+1)-1:0] level,
   output logic                   empty,
   input  wire                    pop,
   output mrsp_pkg::rsp_item_type rsp_item
);
   localparam int AW = $clog2(mrsp_pkg::OQ_DEPTH);
   localparam int CW = $clog2(mrsp_pkg::OQ_DEPTH + 1);

   mrsp_pkg::rsp_item_type oq_ff [mrsp_pkg::OQ_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          pop_ok;

   assign empty = (count_ff == '0);
   assign level = count_ff;
   assign rsp_item = oq_ff[rd_ptr_ff];
   assign pop_ok = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + CW'(wr) - CW'(pop_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         oq_ff[wr_ptr_ff] <= wr_item;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/mrsp_back.sv
`default_nettype none
`include "modbus_register_slave_pdu_assert.svh"
module mrsp_back #(
   parameter int NUM_REGS = mrsp_pkg::NUM_REGS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mrsp_pkg::cfg_type      cfg,
   input  wire                    head_valid,
   input  mrsp_pkg::fq_entry_type head,
   output logic                   deq,
   input  wire [$clog2(mrsp_pkg::OQ_DEPTH+1)-1:0] oq_level,
   output logic                   oq_wr,
   output mrsp_pkg::rsp_item_type oq_item
);
   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int LW = $clog2(mrsp_pkg::OQ_DEPTH + 1);
   localparam logic [16:0] NUM_W = 17'(NUM_REGS);

   logic [15:0] regs_mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;

   mrsp_pkg::back_state_type state_ff, state_in;
   logic [7:0]  fc_ff, fc_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] qty_ff, qty_in;
   logic [7:0]  dbc_ff, dbc_in;
   logic [7:0]  held_ff, held_in;
   logic [6:0]  wc_ff, wc_in;
   logic [7:0]  ec_ff, ec_in;
   logic        err_ff, err_in;
   logic        pend_ff, pend_in;
   logic [7:0]  rpos_ff, rpos_in;

   logic        s2_valid_ff, s2_valid_in;
   logic        s2_rv_ff, s2_rv_in;
   logic [7:0]  s2_byte_ff, s2_byte_in;
   logic        s2_last_ff, s2_last_in;
   logic        s2_mem_ff, s2_mem_in;
   logic        s2_lo_ff, s2_lo_in;
   logic        s2_inr_ff, s2_inr_in;
   logic [15:0] rd_data_ff;
   logic        rd_vld_ff;

   logic        is_req, lst, run_take, pull_go, space;
   logic [7:0]  pos, posa, b;
   logic [7:0]  a_fc;
   logic        a_err;
   logic        take_st, fin_st, st_en, st_act, st_ok, wr_en, st_raise;
   logic        fill_act;
   logic [15:0] st_val;
   logic [16:0] st_reg;
   logic [7:0]  rel;
   logic [16:0] rreg;
   logic [AW-1:0] rd_idx;
   logic [7:0]  rd_byte;

   assign is_req = (head.item.cmd == mrsp_pkg::CMD_REQ);
   assign lst = head.item.in_last;
   assign pos = head.pos;
   assign b = head.item.in_byte;
   assign posa = (pos == 8'hFF) ? 8'hFF : pos + 8'd1;
   assign space = ({1'b0, oq_level} + (LW + 1)'(s2_valid_ff)) < (LW + 1)'(mrsp_pkg::OQ_DEPTH);
   assign run_take = head_valid && (state_ff == mrsp_pkg::BK_RUN) && is_req;
   assign pull_go = head_valid && (state_ff == mrsp_pkg::BK_RUN) && !is_req && space;
   assign deq = run_take || pull_go;

   assign a_fc = (pos == 8'd0) ? b : fc_ff;
   assign a_err = (pos == 8'd0) ? ((b != mrsp_pkg::FC_READ) && (b != mrsp_pkg::FC_WRITE))
                                : err_ff;

   // register store unit
   assign take_st = run_take && (pos >= 8'd6) && (a_fc == mrsp_pkg::FC_WRITE) && !a_err
                    && pos[0];
   assign fin_st = run_take && lst && (a_fc == mrsp_pkg::FC_WRITE) && !a_err
                   && (posa > 8'd6) && posa[0];
   assign st_en = take_st || fin_st || (state_ff == mrsp_pkg::BK_FILL);
   assign st_val = take_st ? {held_ff, b} : (fin_st ? {b, 8'h00} : 16'h0000);
   assign st_act = st_en && !err_ff && ({9'd0, wc_ff} < qty_ff);
   assign st_reg = {1'b0, start_ff} + {10'd0, wc_ff};
   assign st_ok = (st_reg < NUM_W) && cfg.mask[st_reg[mrsp_pkg::MASK_IW-1:0]];
   assign wr_en = st_act && st_ok;
   assign st_raise = st_act && !st_ok;
   assign fill_act = (state_ff == mrsp_pkg::BK_FILL) && st_act;

   // response byte address
   assign rel = rpos_ff - 8'd2;
   assign rreg = {1'b0, start_ff} + {10'd0, rel[7:1]};
   assign rd_idx = rreg[AW-1:0];

   always_comb begin
      state_in = state_ff;
      fc_in = fc_ff;
      start_in = start_ff;
      qty_in = qty_ff;
      dbc_in = dbc_ff;
      held_in = held_ff;
      wc_in = wc_ff;
      ec_in = ec_ff;
      err_in = err_ff;
      pend_in = pend_ff;
      rpos_in = rpos_ff;
      s2_valid_in = 1'b0;
      s2_rv_in = 1'b0;
      s2_byte_in = 8'd0;
      s2_last_in = 1'b0;
      s2_mem_in = 1'b0;
      s2_lo_in = rpos_ff[0];
      s2_inr_in = rreg < NUM_W;
      if (run_take) begin
         unique case (pos)
            8'd0: begin
               fc_in = b;
               start_in = 16'd0;
               qty_in = 16'd0;
               dbc_in = 8'd0;
               held_in = 8'd0;
               wc_in = 7'd0;
               ec_in = 8'd0;
               err_in = a_err;
               if (a_err) begin
                  ec_in = cfg.exc_fn;
               end
            end
            8'd1: start_in = {b, 8'h00};
            8'd2: start_in = {start_ff[15:8], b};
            8'd3: qty_in = {b, 8'h00};
            8'd4: qty_in = {qty_ff[15:8], b};
            8'd5: dbc_in = b;
            default: begin
               if ((a_fc == mrsp_pkg::FC_WRITE) && !a_err && !pos[0]) begin
                  held_in = b;
               end
            end
         endcase
         if ((a_fc == mrsp_pkg::FC_WRITE) && !a_err
             && ((pos == 8'd5) || (lst && (posa < 8'd6)))) begin
            if (mrsp_pkg::qty_bad_write(qty_in, dbc_in)) begin
               err_in = 1'b1;
               ec_in = cfg.exc_qty;
            end else if (mrsp_pkg::range_bad(start_in, qty_in, NUM_W)) begin
               err_in = 1'b1;
               ec_in = cfg.exc_addr;
            end
         end
         if (lst && (a_fc == mrsp_pkg::FC_READ) && !a_err) begin
            if (mrsp_pkg::qty_bad_read(qty_in)) begin
               err_in = 1'b1;
               ec_in = cfg.exc_qty;
            end else if (mrsp_pkg::range_bad(start_in, qty_in, NUM_W)) begin
               err_in = 1'b1;
               ec_in = cfg.exc_addr;
            end
         end
         if (lst) begin
            pend_in = 1'b1;
            rpos_in = 8'd0;
            if (a_fc == mrsp_pkg::FC_WRITE) begin
               state_in = mrsp_pkg::BK_FILL;
            end
         end else begin
            pend_in = 1'b0;
         end
      end
      if (state_ff == mrsp_pkg::BK_FILL && !st_act) begin
         state_in = mrsp_pkg::BK_RUN;
      end
      if (st_raise) begin
         err_in = 1'b1;
         ec_in = cfg.exc_addr;
      end
      if (wr_en) begin
         wc_in = wc_ff + 7'd1;
      end
      if (pull_go) begin
         s2_valid_in = 1'b1;
         if (pend_ff) begin
            s2_rv_in = 1'b1;
            if (err_ff) begin
               s2_last_in = (rpos_ff >= 8'd1);
               s2_byte_in = (rpos_ff == 8'd0) ? fc_ff + mrsp_pkg::EXC_OFFSET : ec_ff;
            end else if (fc_ff == mrsp_pkg::FC_WRITE) begin
               s2_last_in = (rpos_ff >= 8'd4);
               unique case (rpos_ff)
                  8'd0: s2_byte_in = fc_ff;
                  8'd1: s2_byte_in = start_ff[15:8];
                  8'd2: s2_byte_in = start_ff[7:0];
                  8'd3: s2_byte_in = qty_ff[15:8];
                  default: s2_byte_in = qty_ff[7:0];
               endcase
            end else begin
               s2_last_in = ({9'd0, rpos_ff} + 17'd1) >= (17'd2 + {qty_ff, 1'b0});
               if (rpos_ff == 8'd0) begin
                  s2_byte_in = fc_ff;
               end else if (rpos_ff == 8'd1) begin
                  s2_byte_in = {qty_ff[6:0], 1'b0};
               end else begin
                  s2_mem_in = 1'b1;
               end
            end
            if (s2_last_in) begin
               pend_in = 1'b0;
               rpos_in = 8'd0;
            end else if (rpos_ff != 8'hFF) begin
               rpos_in = rpos_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrsp_pkg::BK_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= 8'd0;
         start_ff <= 16'd0;
         qty_ff <= 16'd0;
         dbc_ff <= 8'd0;
         held_ff <= 8'd0;
         wc_ff <= 7'd0;
         ec_ff <= 8'd0;
         err_ff <= 1'b0;
         pend_ff <= 1'b0;
         rpos_ff <= 8'd0;
         s2_valid_ff <= 1'b0;
         vld_ff <= '0;
      end else begin
         fc_ff <= fc_in;
         start_ff <= start_in;
         qty_ff <= qty_in;
         dbc_ff <= dbc_in;
         held_ff <= held_in;
         wc_ff <= wc_in;
         ec_ff <= ec_in;
         err_ff <= err_in;
         pend_ff <= pend_in;
         rpos_ff <= rpos_in;
         s2_valid_ff <= s2_valid_in;
         if (wr_en) begin
            vld_ff[st_reg[AW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_rv_ff <= s2_rv_in;
      s2_byte_ff <= s2_byte_in;
      s2_last_ff <= s2_last_in;
      s2_mem_ff <= s2_mem_in;
      s2_lo_ff <= s2_lo_in;
      s2_inr_ff <= s2_inr_in;
      rd_vld_ff <= vld_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_mem[st_reg[AW-1:0]] <= st_val;
      end
      rd_data_ff <= regs_mem[rd_idx];
   end

   // registers never written read as zero
   assign rd_byte = (s2_inr_ff && rd_vld_ff) ? (s2_lo_ff ? rd_data_ff[7:0] : rd_data_ff[15:8])
                                             : 8'd0;
   assign oq_wr = s2_valid_ff;
   assign oq_item = '{out_valid: s2_rv_ff,
                      out_byte: s2_mem_ff ? rd_byte : s2_byte_ff,
                      out_last: s2_last_ff};

   `MRSP_ASSERT_IMPL(a_store_writable, wr_en, (st_reg < NUM_W) && cfg.mask[st_reg[5:0]])
   `MRSP_ASSERT_IMPL(a_outq_room, s2_valid_ff, oq_level < LW'(mrsp_pkg::OQ_DEPTH))
   `MRSP_ASSERT(a_fill_progress, fill_act |=> (wc_ff == $past(wc_ff) + 7'd1) || err_ff)
endmodule
`default_nettype wire

// File: sim/tb_modbus_register_slave_pdu.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_modbus_register_slave_pdu;
   localparam int NREGS = mrsp_pkg::NUM_REGS_DEF;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      mrsp_pkg::req_item_type item;
      logic                   typed;
      mrsp_pkg::rsp_item_type rsp;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full;
   mrsp_pkg::req_item_type req_item = '0;
   logic         empty;
   logic         pop = 1'b0;
   mrsp_pkg::rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [4:0]   paddr = '0;
   logic [63:0]  pwdata = '0;
   logic [63:0]  prdata;
   logic         pready;

   mrsp_pkg::rsp_item_type pending_bytes[$];
   table_row_type dir_rows[$];
   int  errors = 0;
   int  items_sent = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   int  hold_left = 0;
   int  pop_gap = 0;
   int  idle_cycles = 0;

   // predictor state
   logic [63:0] m_mask = '0;
   logic [7:0]  m_exc_fn = 8'd1, m_exc_addr = 8'd2, m_exc_qty = 8'd3;
   logic [7:0]  p_pos, p_fc, p_dbc, p_hi, p_err, p_rpos;
   logic [15:0] p_start, p_qty;
   logic [6:0]  p_wcnt;
   bit          p_errf, p_pend;
   logic [15:0] p_regs[NREGS];

   modbus_register_slave_pdu dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void flag_error(input logic [7:0] c);
      p_errf = 1'b1;
      p_err = c;
   endfunction

   function automatic bit span_fits();
      return int'(p_start) + int'(p_qty) <= NREGS;
   endfunction

   function automatic void check_rd();
      if (p_qty == 16'd0 || p_qty > mrsp_pkg::MAX_READ_QTY) flag_error(m_exc_qty);
      else if (!span_fits()) flag_error(m_exc_addr);
   endfunction

   function automatic void check_wr();
      if (p_qty == 16'd0 || p_qty > mrsp_pkg::MAX_WRITE_QTY
          || int'(p_dbc) != 2 * int'(p_qty))
         flag_error(m_exc_qty);
      else if (!span_fits()) flag_error(m_exc_addr);
   endfunction

   function automatic void store_reg(input logic [15:0] v);
      int r;
      if (p_errf || {9'd0, p_wcnt} >= p_qty) return;
      r = int'(p_start) + int'(p_wcnt);
      if (r >= NREGS || !m_mask[r]) begin
         flag_error(m_exc_addr);
         return;
      end
      p_regs[r] = v;
      p_wcnt = p_wcnt + 7'd1;
   endfunction

   function automatic void close_request();
      int pos;
      pos = int'(p_pos);
      if (p_fc == mrsp_pkg::FC_READ && !p_errf) check_rd();
      if (p_fc == mrsp_pkg::FC_WRITE && !p_errf) begin
         if (pos < 6) check_wr();
         if (!p_errf && pos > 6 && ((pos - 6) & 1) != 0) store_reg({p_hi, 8'd0});
         while (!p_errf && {9'd0, p_wcnt} < p_qty) store_reg(16'd0);
      end
      p_pend = 1'b1;
      p_rpos = 8'd0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      int pos;
      pos = int'(p_pos);
      if (pos == 0) begin
         p_fc = b; p_start = '0; p_qty = '0; p_dbc = '0; p_hi = '0;
         p_wcnt = '0; p_err = '0; p_errf = 1'b0;
         if (b != mrsp_pkg::FC_READ && b != mrsp_pkg::FC_WRITE) flag_error(m_exc_fn);
      end else if (pos == 1) p_start = {b, 8'd0};
      else if (pos == 2) p_start = p_start | {8'd0, b};
      else if (pos == 3) p_qty = {b, 8'd0};
      else if (pos == 4) p_qty = p_qty | {8'd0, b};
      else if (pos == 5) begin
         p_dbc = b;
         if (p_fc == mrsp_pkg::FC_WRITE && !p_errf) check_wr();
      end else if (p_fc == mrsp_pkg::FC_WRITE && !p_errf) begin
         if (((pos - 6) & 1) == 0) p_hi = b;
         else store_reg({p_hi, b});
      end
      if (p_pos < 8'd255) p_pos = p_pos + 8'd1;
   endfunction

   function automatic logic [7:0] reply_byte(input int r, output bit last);
      int q, rg;
      logic [15:0] v;
      q = int'(p_qty);
      if (p_errf) begin
         last = (r >= 1);
         return r == 0 ? p_fc + mrsp_pkg::EXC_OFFSET : p_err;
      end
      if (p_fc == mrsp_pkg::FC_WRITE) begin
         last = (r >= 4);
         case (r)
            0: return p_fc;
            1: return p_start[15:8];
            2: return p_start[7:0];
            3: return p_qty[15:8];
            default: return p_qty[7:0];
         endcase
      end
      last = (r + 1 >= 2 + 2 * q);
      if (r == 0) return p_fc;
      if (r == 1) return 8'((2 * q) & 255);
      rg = int'(p_start) + (r - 2) / 2;
      v = rg < NREGS ? p_regs[rg] : 16'd0;
      return ((r - 2) & 1) == 0 ? v[15:8] : v[7:0];
   endfunction

   function automatic bit predict_item(input mrsp_pkg::req_item_type it,
                                       output mrsp_pkg::rsp_item_type o);
      bit last;
      o = '0;
      if (it.cmd == mrsp_pkg::CMD_REQ) begin
         p_pend = 1'b0;
         parse_byte(it.in_byte);
         if (it.in_last) begin
            close_request();
            p_pos = 8'd0;
         end
         return 0;
      end
      if (!p_pend) return 1;
      o.out_valid = 1'b1;
      o.out_byte = reply_byte(int'(p_rpos), last);
      o.out_last = last;
      if (last) begin
         p_pend = 1'b0;
         p_rpos = 8'd0;
      end else if (p_rpos < 8'd255) p_rpos = p_rpos + 8'd1;
      return 1;
   endfunction

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic send_item(input mrsp_pkg::req_item_type it, input bit typed,
                            input mrsp_pkg::rsp_item_type want);
      mrsp_pkg::rsp_item_type o;
      if (!quiet && $urandom_range(0, 15) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      items_sent++;
      if (predict_item(it, o)) pending_bytes.push_back(typed ? want : o);
   endtask

   task automatic send_req(input logic [7:0] b, input bit last);
      send_item('{cmd: mrsp_pkg::CMD_REQ, in_byte: b, in_last: last}, 0, '0);
   endtask

   task automatic send_pulls(input int n);
      repeat (n) send_item('{cmd: mrsp_pkg::CMD_PULL, in_byte: 8'($urandom),
                             in_last: 1'($urandom)}, 0, '0);
   endtask

   task automatic add_req(input logic [7:0] b, input bit last);
      dir_rows.push_back('{item: '{mrsp_pkg::CMD_REQ, b, last}, typed: 0, rsp: '0});
   endtask

   task automatic add_pull(input bit typed, input bit valid, input logic [7:0] b,
                           input bit last);
      dir_rows.push_back('{item: '{mrsp_pkg::CMD_PULL, 8'hA5, 1'b0}, typed: typed,
                           rsp: '{valid, b, last}});
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      push <= 1'b0;
      wait (pending_bytes.size() == 0);
      repeat (150) @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         mrsp_pkg::CSR_MASK:     m_mask = val;
         mrsp_pkg::CSR_EXC_FN:   m_exc_fn = val[7:0];
         mrsp_pkg::CSR_EXC_ADDR: m_exc_addr = val[7:0];
         default:                m_exc_qty = val[7:0];
      endcase
   endtask

   task automatic one_request();
      logic [7:0] q[$];
      logic [7:0] fc;
      int kind, st, qt, pulls, cut;
      kind = $urandom_range(0, 19);
      st = $urandom_range(0, NREGS - 1);
      qt = $urandom_range(1, (NREGS - st) < 4 ? NREGS - st : 4);
      if ($urandom_range(0, 9) == 0) begin
         st = 0;
         qt = $urandom_range(1, NREGS);
      end
      fc = kind < 9 ? mrsp_pkg::FC_READ : mrsp_pkg::FC_WRITE;
      if (kind == 16) fc = 8'($urandom);
      if (kind == 17) qt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(120, 300);
      if (kind == 18) st = $urandom_range(NREGS - 2, 65535);
      q = {fc, 8'(st >> 8), 8'(st), 8'(qt >> 8), 8'(qt)};
      if (fc == mrsp_pkg::FC_WRITE) begin
         q.push_back(8'(2 * qt + (kind == 17 && qt < 8 ? 1 : 0)));
         for (int i = 0; i < 2 * qt && i < 260; i++) q.push_back(8'($urandom));
      end
      if (kind == 19) begin
         q = {};
         repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, q.size());
         while (q.size() > cut) void'(q.pop_back());
      end
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
      foreach (q[i]) send_req(q[i], i == q.size() - 1 || (kind == 19 && $urandom_range(0, 3) == 0));
      pulls = fc == mrsp_pkg::FC_READ ? 2 + 2 * qt : 5;
      if (pulls > 140) pulls = 140;
      if ($urandom_range(0, 4) == 0) pulls = $urandom_range(0, pulls + 3);
      send_pulls(pulls);
   endtask

   task automatic run_requests(input int n);
      int first;
      first = items_sent;
      while (items_sent - first < n) one_request();
   endtask

   // result checking and receiver idling
   initial begin
      mrsp_pkg::rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (pending_bytes.size() == 0) begin
               report("unexpected item", rsp_item.out_byte, 8'h00);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_item.out_valid !== want.out_valid)
                  report("out_valid", 8'(rsp_item.out_valid), 8'(want.out_valid));
               if (rsp_item.out_byte !== want.out_byte)
                  report("out_byte", rsp_item.out_byte, want.out_byte);
               if (rsp_item.out_last !== want.out_last)
                  report("out_last", 8'(rsp_item.out_last), 8'(want.out_last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
            pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            pop_gap = $urandom_range(1, 18) - 1;
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      p_pos = '0; p_fc = '0; p_dbc = '0; p_hi = '0; p_err = '0; p_rpos = '0;
      p_start = '0; p_qty = '0; p_wcnt = '0; p_errf = 0; p_pend = 0;
      foreach (p_regs[i]) p_regs[i] = '0;
      // nothing pending
      add_pull(1, 0, 8'h00, 0);
      // read quantity over the limit
      add_req(mrsp_pkg::FC_READ, 0); add_req(8'h00, 0); add_req(8'h00, 0);
      add_req(8'h00, 0); add_req(8'h7E, 1);
      add_pull(1, 1, 8'h83, 0); add_pull(1, 1, 8'h03, 1);
      // unsupported function code
      add_req(8'hFF, 1);
      add_pull(1, 1, 8'h7F, 0); add_pull(1, 1, 8'h01, 1);
      // write to a read-only last register
      add_req(mrsp_pkg::FC_WRITE, 0); add_req(8'h00, 0); add_req(8'h3F, 0);
      add_req(8'h00, 0); add_req(8'h01, 0); add_req(8'h02, 0); add_req(8'hAB, 0);
      add_req(8'hCD, 1);
      add_pull(1, 1, 8'h90, 0); add_pull(1, 1, 8'h02, 1);
      // read of the last register, still zero
      add_req(mrsp_pkg::FC_READ, 0); add_req(8'h00, 0); add_req(8'h3F, 0); add_req(8'h00, 0);
      add_req(8'h01, 1);
      add_pull(0, 0, 0, 0); add_pull(0, 0, 0, 0); add_pull(0, 0, 0, 0); add_pull(0, 0, 0, 0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rsp);

      csr_write(mrsp_pkg::CSR_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(mrsp_pkg::CSR_EXC_FN, 64'hFF);
      csr_write(mrsp_pkg::CSR_EXC_ADDR, 64'hFF);
      csr_write(mrsp_pkg::CSR_EXC_QTY, 64'hFF);
      run_requests(200);
      // hold the receiver off while a long read response piles up
      hold_req = 1;
      send_req(mrsp_pkg::FC_READ, 0); send_req(8'h00, 0); send_req(8'h00, 0);
      send_req(8'h00, 0); send_req(8'h40, 1);
      send_pulls(130);
      push <= 1'b0;
      wait (pending_bytes.size() == 0);

      csr_write(mrsp_pkg::CSR_MASK, {$urandom, $urandom});
      csr_write(mrsp_pkg::CSR_EXC_FN, 64'h00);
      csr_write(mrsp_pkg::CSR_EXC_ADDR, 64'h00);
      csr_write(mrsp_pkg::CSR_EXC_QTY, 64'h00);
      run_requests(200);

      csr_write(mrsp_pkg::CSR_MASK, {$urandom, $urandom} | {$urandom, $urandom});
      csr_write(mrsp_pkg::CSR_EXC_FN, 64'($urandom_range(0, 255)));
      csr_write(mrsp_pkg::CSR_EXC_ADDR, 64'($urandom_range(0, 255)));
      csr_write(mrsp_pkg::CSR_EXC_QTY, 64'($urandom_range(0, 255)));
      run_requests(200);
      quiet = 1;
      run_requests(120);
      push <= 1'b0;
      wait (pending_bytes.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
